### hdl/cidh_pkg.sv
// ----------------------------------------------------------------------------
// CAN ID handler table package
// Shared constants, payload structs, memory port structs and the sequencer
// state type for the CAN identifier handler table.
// ----------------------------------------------------------------------------
package cidh_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
    localparam int ID_BITS     = 11;
    localparam int TAG_BITS    = 8;

    // Request codes.
    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_DEFAULT  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_DUP  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [ID_BITS-1:0]  msg_id;
        logic [TAG_BITS-1:0] handler_tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          status;
        logic                found;
        logic [TAG_BITS-1:0] result_tag;
        logic                used_default;
    } out_item_t;

    typedef struct packed {
        logic [ID_BITS-1:0]  id;
        logic [TAG_BITS-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        entry_t              data;
    } mem_wr_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
    } mem_rd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } seq_state_t;

endpackage

### hdl/cidh_entry_mem.sv
// ----------------------------------------------------------------------------
// CAN ID handler table entry memory
// Single-port-write, single-port-read synchronous memory holding the
// identifier and tag of every regular entry. Read data is registered.
// ----------------------------------------------------------------------------
module cidh_entry_mem (
    input  logic             clk,
    input  cidh_pkg::mem_wr_t wr,
    input  cidh_pkg::mem_rd_t rd,
    output cidh_pkg::entry_t  rd_data
);
    import cidh_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/cidh_seq.sv
// ----------------------------------------------------------------------------
// CAN ID handler table sequencer
// Takes one request at a time, scans the entry memory one entry per cycle
// for an exact identifier match, updates the count and default handler,
// appends new entries, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module cidh_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [cidh_pkg::CNT_BITS-1:0]    capacity,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cidh_pkg::in_item_t               in_item,
    output logic                             res_valid,
    input  logic                             res_ready,
    output cidh_pkg::out_item_t              res_item,
    output cidh_pkg::mem_wr_t                mem_wr,
    output cidh_pkg::mem_rd_t                mem_rd,
    input  cidh_pkg::entry_t                 mem_rd_data
);
    import cidh_pkg::*;

    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);

    seq_state_t          state_reg, state_next;
    logic [1:0]          req_reg, req_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [CNT_BITS-1:0] n_reg, n_next;
    logic [CNT_BITS-1:0] addr_reg, addr_next;
    logic                pend_reg, pend_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                dflt_present_reg, dflt_present_next;
    logic [TAG_BITS-1:0] dflt_tag_reg, dflt_tag_next;
    out_item_t           res_reg, res_next;

    logic [CNT_BITS-1:0] cap_eff;
    logic [CNT_BITS-1:0] regular_cnt;
    logic                table_full;
    logic                hit;
    logic                issue;

    assign cap_eff     = (capacity > DEPTH_CNT) ? DEPTH_CNT : capacity;
    assign table_full  = (count_reg >= cap_eff);
    assign regular_cnt = count_reg - CNT_BITS'(dflt_present_reg);
    assign hit         = pend_reg && (mem_rd_data.id == id_reg);
    assign issue       = (state_reg == ST_SCAN) && (addr_reg < n_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESULT);
    assign res_item  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pend_reg         <= 1'b0;
            count_reg        <= '0;
            dflt_present_reg <= 1'b0;
            dflt_tag_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            pend_reg         <= pend_next;
            count_reg        <= count_next;
            dflt_present_reg <= dflt_present_next;
            dflt_tag_reg     <= dflt_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        id_reg   <= id_next;
        tag_reg  <= tag_next;
        n_reg    <= n_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        id_next           = id_reg;
        tag_next          = tag_reg;
        n_next            = n_reg;
        addr_next         = addr_reg;
        pend_next         = 1'b0;
        count_next        = count_reg;
        dflt_present_next = dflt_present_reg;
        dflt_tag_next     = dflt_tag_reg;
        res_next          = res_reg;
        mem_wr            = '0;
        mem_rd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = in_item.req_type;
                    id_next   = in_item.msg_id;
                    tag_next  = in_item.handler_tag;
                    n_next    = regular_cnt;
                    addr_next = '0;
                    res_next  = '0;
                    case (in_item.req_type)
                        REQ_REGISTER:
                        begin
                            if (table_full)
                            begin
                                res_next.status = STATUS_FULL;
                                state_next      = ST_RESULT;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        REQ_DEFAULT:
                        begin
                            if (table_full)
                            begin
                                res_next.status = STATUS_FULL;
                            end
                            else if (dflt_present_reg)
                            begin
                                res_next.status = STATUS_DUP;
                            end
                            else
                            begin
                                dflt_present_next = 1'b1;
                                dflt_tag_next     = in_item.handler_tag;
                                count_next        = count_reg + 1'b1;
                            end
                            state_next = ST_RESULT;
                        end
                        REQ_LOOKUP:
                        begin
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    // A match ends the scan; no further read is issued.
                    if (req_reg == REQ_REGISTER)
                    begin
                        res_next.status = STATUS_DUP;
                    end
                    else
                    begin
                        res_next.found      = 1'b1;
                        res_next.result_tag = mem_rd_data.tag;
                    end
                    state_next = ST_RESULT;
                end
                else if (!pend_reg && !issue)
                begin
                    // Every regular entry was compared without a match.
                    if (req_reg == REQ_REGISTER)
                    begin
                        if (n_reg < DEPTH_CNT)
                        begin
                            mem_wr.en       = 1'b1;
                            mem_wr.addr     = n_reg[IDX_BITS-1:0];
                            mem_wr.data.id  = id_reg;
                            mem_wr.data.tag = tag_reg;
                            count_next      = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    else if (dflt_present_reg)
                    begin
                        res_next.found        = 1'b1;
                        res_next.result_tag   = dflt_tag_reg;
                        res_next.used_default = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    mem_rd.en   = issue;
                    mem_rd.addr = addr_reg[IDX_BITS-1:0];
                    pend_next   = issue;
                    if (issue)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
            end

            ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hdl/can_id_handler_table.sv
// ----------------------------------------------------------------------------
// CAN ID handler table
// Maps CAN message identifiers to handler tags with a configurable capacity
// and an optional default handler. Holds the capacity register and the
// output register in front of the result channel.
// ----------------------------------------------------------------------------
//  channel   signals                      direction  transaction
//  in        in_valid/in_ready/in_data    input      one request
//  out       out_valid/out_ready/out_data output     one result per request
//  cfg       cfg_we/cfg_wdata             input      table_capacity write
//
// A register or lookup scans the n regular entries one per cycle through the
// entry memory read port and stops early on a match; full checks, default
// registrations and unknown requests skip the scan.
// Reset clears the count and the default handler; no memory clearing pass.
// A new request is taken while the previous result waits in the output
// register; the sequencer only stalls when its own result cannot move there.
// ----------------------------------------------------------------------------
module can_id_handler_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cidh_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cidh_pkg::out_item_t           out_data,
    input  logic                          cfg_we,
    input  logic [cidh_pkg::CNT_BITS-1:0] cfg_wdata
);
    import cidh_pkg::*;

    logic [CNT_BITS-1:0] capacity_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                res_valid;
    logic                res_ready;
    out_item_t           res_item;
    mem_wr_t             mem_wr;
    mem_rd_t             mem_rd;
    entry_t              mem_rd_data;

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CNT_BITS'(TABLE_DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cidh_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_item    (res_item),
        .mem_wr      (mem_wr),
        .mem_rd      (mem_rd),
        .mem_rd_data (mem_rd_data)
    );

    cidh_entry_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_rd_data)
    );

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// CAN ID handler table testbench
// Drives register, register-default, lookup and unused requests through the
// valid/ready request channel and checks every response against a directed
// expectation or a behavioral model kept in step with each accepted request.
// A short directed table covers capacity extremes, duplicates, the default
// fallback and the full table. Random phases vary capacity and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    import cidh_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         NO_CAP_WRITE = -1;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         PHASE_ITEMS  = 450;
    localparam int         ID_MAX       = (1 << ID_BITS) - 1;
    localparam int         TAG_MAX      = (1 << TAG_BITS) - 1;

    typedef struct {
        int        cap_wr;
        in_item_t  req;
        bit        typed;
        out_item_t rsp;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            req_bus;
    logic                out_valid;
    logic                out_ready;
    out_item_t           rsp_bus;
    logic                cfg_we;
    logic [CNT_BITS-1:0] cfg_wdata;

    // Behavioral copy of the table and the capacity register.
    logic [ID_BITS-1:0]  tbl_id [TABLE_DEPTH];
    logic [TAG_BITS-1:0] tbl_tag [TABLE_DEPTH];
    int unsigned         tbl_count;
    bit                  dflt_on;
    logic [TAG_BITS-1:0] dflt_tag;
    logic [CNT_BITS-1:0] cap_reg;

    out_item_t   pending_responses[$];
    dir_row_t    directed_rows[$];
    int unsigned fail_count;
    int unsigned send_idle;
    int unsigned recv_idle;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    can_id_handler_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (req_bus),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic out_item_t compute_response(input in_item_t rq);
        out_item_t   rsp;
        int unsigned limit;
        int unsigned regular;
        int          hit;
        int          i;
        rsp     = '0;
        limit   = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : cap_reg;
        regular = tbl_count - (dflt_on ? 1 : 0);
        hit     = -1;
        for (i = 0; i < regular; i++)
        begin
            if (hit < 0 && tbl_id[i] == rq.msg_id)
                hit = i;
        end
        case (rq.req_type)
            REQ_REGISTER:
            begin
                // The full check wins over the duplicate check.
                if (tbl_count >= limit)
                    rsp.status = STATUS_FULL;
                else if (hit >= 0)
                    rsp.status = STATUS_DUP;
                else if (regular < TABLE_DEPTH)
                begin
                    tbl_id[regular]  = rq.msg_id;
                    tbl_tag[regular] = rq.handler_tag;
                    tbl_count++;
                end
                else
                    rsp.status = STATUS_FULL;
            end
            REQ_DEFAULT:
            begin
                if (tbl_count >= limit)
                    rsp.status = STATUS_FULL;
                else if (dflt_on)
                    rsp.status = STATUS_DUP;
                else
                begin
                    dflt_on  = 1'b1;
                    dflt_tag = rq.handler_tag;
                    tbl_count++;
                end
            end
            REQ_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    rsp.found      = 1'b1;
                    rsp.result_tag = tbl_tag[hit];
                end
                else if (dflt_on)
                begin
                    rsp.found        = 1'b1;
                    rsp.result_tag   = dflt_tag;
                    rsp.used_default = 1'b1;
                end
            end
            default:
                ;
        endcase
        return rsp;
    endfunction

    function automatic in_item_t random_request();
        in_item_t    rq;
        int unsigned pick;
        int unsigned regular;
        regular = tbl_count - (dflt_on ? 1 : 0);
        pick    = $urandom_range(99);
        if (pick < 12)
            rq.req_type = REQ_REGISTER;
        else if (pick < 16)
            rq.req_type = REQ_DEFAULT;
        else if (pick < 95)
            rq.req_type = REQ_LOOKUP;
        else
            rq.req_type = REQ_UNUSED;
        // Favor identifiers already in the table so lookups hit and
        // registrations collide.
        pick = $urandom_range(9);
        if (pick < 5 && regular > 0)
            rq.msg_id = tbl_id[$urandom_range(regular - 1)];
        else if (pick < 7)
            rq.msg_id = ID_BITS'($urandom_range(15));
        else if (pick == 7)
            rq.msg_id = $urandom_range(1) ? ID_BITS'(ID_MAX) : '0;
        else
            rq.msg_id = ID_BITS'($urandom_range(ID_MAX));
        rq.handler_tag = TAG_BITS'($urandom_range(TAG_MAX));
        return rq;
    endfunction

    task automatic add_row(input int cap_wr, input logic [1:0] req_type,
                           input int msg_id, input int tag, input bit typed,
                           input logic [1:0] status, input bit found,
                           input int result_tag, input bit used_default);
        dir_row_t row;
        row.cap_wr               = cap_wr;
        row.req.req_type         = req_type;
        row.req.msg_id           = ID_BITS'(msg_id);
        row.req.handler_tag      = TAG_BITS'(tag);
        row.typed                = typed;
        row.rsp.status           = status;
        row.rsp.found            = found;
        row.rsp.result_tag       = TAG_BITS'(result_tag);
        row.rsp.used_default     = used_default;
        directed_rows.push_back(row);
    endtask

    task automatic send_request(input in_item_t rq, input bit typed,
                                input out_item_t typed_rsp);
        out_item_t rsp;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        req_bus  = rq;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        rsp = compute_response(rq);
        pending_responses.push_back(typed ? typed_rsp : rsp);
    endtask

    task automatic write_capacity(input logic [CNT_BITS-1:0] value);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        cap_reg   = value;
    endtask

    // Response side: ready changes at the falling edge, checks at the rising.
    initial
    begin
        bit hold_seen;
        hold_seen = 1'b0;
        out_ready = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_seen)
            begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        out_item_t want;
        fail_count = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response %p", rsp_bus);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (rsp_bus.status !== want.status || rsp_bus.found !== want.found
                        || rsp_bus.result_tag !== want.result_tag
                        || rsp_bus.used_default !== want.used_default)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("response mismatch: expected %p, got %p",
                                     want, rsp_bus);
                    end
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned caps[4];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_bus      = '0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        hold_request = 1'b0;
        send_idle    = 29;
        recv_idle    = 84;
        tbl_count    = 0;
        dflt_on      = 1'b0;
        dflt_tag     = '0;
        cap_reg      = TABLE_DEPTH;

        // Zero capacity, empty table, unused request type.
        add_row(0, REQ_REGISTER, 'h123, 'h5A, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_DEFAULT, 0, 'h11, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h123, 0, 1, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_UNUSED, ID_MAX, TAG_MAX, 1, STATUS_OK, 0, 0, 0);
        // Capacity above the table depth, identifier and tag extremes.
        add_row(63, REQ_REGISTER, 0, 0, 1, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_REGISTER, ID_MAX, TAG_MAX, 1, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_REGISTER, ID_MAX, 'h3C, 1, STATUS_DUP, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, ID_MAX, 0, 1, STATUS_OK, 1, TAG_MAX, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 0, TAG_MAX, 1, STATUS_OK, 1, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h555, 0, 1, STATUS_OK, 0, 0, 0);
        // Default handler, its duplicate and the fallback on a miss.
        add_row(NO_CAP_WRITE, REQ_DEFAULT, 'h2AA, 'hA5, 1, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_DEFAULT, 0, 'h5A, 1, STATUS_DUP, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h555, 0, 1, STATUS_OK, 1, 'hA5, 1);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, ID_MAX, 0, 1, STATUS_OK, 1, TAG_MAX, 0);
        add_row(NO_CAP_WRITE, REQ_REGISTER, 'h400, 'h80, 0, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h400, 0, 0, STATUS_OK, 0, 0, 0);
        // Table exactly full: full is reported even for a duplicate.
        add_row(4, REQ_REGISTER, 0, 'h01, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_REGISTER, 'h001, 'h01, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_DEFAULT, 0, 'h33, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h001, 0, 0, STATUS_OK, 0, 0, 0);
        // Capacity lowered below the count keeps the entries.
        add_row(2, REQ_REGISTER, 'h002, 'h02, 1, STATUS_FULL, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_LOOKUP, 'h400, 0, 0, STATUS_OK, 0, 0, 0);
        add_row(NO_CAP_WRITE, REQ_UNUSED, 0, 0, 1, STATUS_OK, 0, 0, 0);
        add_row(32, REQ_REGISTER, 'h003, 'hC3, 0, STATUS_OK, 0, 0, 0);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].cap_wr != NO_CAP_WRITE)
                write_capacity(CNT_BITS'(directed_rows[i].cap_wr));
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].rsp);
        end

        // Capacity grows in steps so registrations keep succeeding for a
        // while in each phase, then drops for the last one.
        caps[0] = $urandom_range(8, 16);
        caps[1] = 24;
        caps[2] = 40;
        caps[3] = $urandom_range(0, TABLE_DEPTH - 1);
        for (phase = 0; phase < 4; phase++)
        begin
            write_capacity(CNT_BITS'(caps[phase]));
            case (phase)
                0:       begin send_idle = 29; recv_idle = 84; end
                1:       begin send_idle = 84; recv_idle = 29; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            // Long response stall while requests keep coming.
            if (phase == 2)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, '0);
        end

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending_responses.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
